### hw/rtl/tfn_pkg.sv
package tfn_pkg;

  // Fixed field and datapath widths
  localparam int CoordW  = 16;
  localparam int EdgeW   = CoordW + 1;
  localparam int ProdW   = 2 * EdgeW;
  localparam int CrossW  = ProdW + 1;
  localparam int MagW    = ProdW;
  localparam int PosW    = 6;
  localparam int NormW   = 30;
  localparam int NormTop = NormW - 1;
  localparam int SqW     = 2 * NormW;
  localparam int Len2W   = SqW + 2;
  localparam int RootW   = Len2W + 1;
  localparam int RootSteps = Len2W / 2 + 1;
  localparam int LenW    = NormW + 1;
  localparam int OutW    = 16;
  localparam int OutMax  = 32767;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
  } tri_t;

  typedef struct packed {
    logic signed [OutW-1:0] normal_x;
    logic signed [OutW-1:0] normal_y;
    logic signed [OutW-1:0] normal_z;
    logic                   degenerate;
  } normal_t;

  // Normalized magnitudes, their signs and the zero flag of one item
  typedef struct packed {
    logic [2:0][NormW-1:0] mag;
    logic [2:0]            neg;
    logic                  degen;
  } side_t;

endpackage

### hw/rtl/tfn_cross.sv
module tfn_cross (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  tfn_pkg::tri_t tri_i,
  output logic          valid_o,
  output tfn_pkg::side_t side_o
);
  import tfn_pkg::*;

  logic [5:0] vld_q;

  logic signed [EdgeW-1:0]  e_q [6];
  logic signed [ProdW-1:0]  p_q [6];
  logic [MagW-1:0]          mag3_q [3];
  logic [2:0]               neg3_q;
  logic [MagW-1:0]          mag4_q [3];
  logic [2:0]               neg4_q;
  logic [MagW-1:0]          max4_q;
  logic [MagW-1:0]          mag5_q [3];
  logic [2:0]               neg5_q;
  logic [PosW-1:0]          pos5_q;
  logic                     degen5_q;
  side_t                    side_q;

  logic signed [CrossW-1:0] n_d [3];
  logic [MagW-1:0]          max_d;
  logic [PosW-1:0]          pos_d;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // Cross product components
  always_comb begin
    n_d[0] = CrossW'(p_q[0]) - CrossW'(p_q[1]);
    n_d[1] = CrossW'(p_q[2]) - CrossW'(p_q[3]);
    n_d[2] = CrossW'(p_q[4]) - CrossW'(p_q[5]);
  end

  // Largest magnitude
  always_comb begin
    max_d = mag3_q[0];
    if (mag3_q[1] > max_d) max_d = mag3_q[1];
    if (mag3_q[2] > max_d) max_d = mag3_q[2];
  end

  // Leading one position of the largest magnitude
  always_comb begin
    pos_d = '0;
    for (int i = 0; i < MagW; i++) begin
      if (max4_q[i]) pos_d = PosW'(i);
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    e_q[0] <= EdgeW'(tri_i.b_x) - EdgeW'(tri_i.a_x);
    e_q[1] <= EdgeW'(tri_i.b_y) - EdgeW'(tri_i.a_y);
    e_q[2] <= EdgeW'(tri_i.b_z) - EdgeW'(tri_i.a_z);
    e_q[3] <= EdgeW'(tri_i.c_x) - EdgeW'(tri_i.a_x);
    e_q[4] <= EdgeW'(tri_i.c_y) - EdgeW'(tri_i.a_y);
    e_q[5] <= EdgeW'(tri_i.c_z) - EdgeW'(tri_i.a_z);

    p_q[0] <= e_q[4] * e_q[2];
    p_q[1] <= e_q[5] * e_q[1];
    p_q[2] <= e_q[5] * e_q[0];
    p_q[3] <= e_q[3] * e_q[2];
    p_q[4] <= e_q[3] * e_q[1];
    p_q[5] <= e_q[4] * e_q[0];

    for (int c = 0; c < 3; c++) begin
      neg3_q[c] <= n_d[c][CrossW-1];
      mag3_q[c] <= n_d[c][CrossW-1] ? MagW'(-n_d[c]) : MagW'(n_d[c]);
    end

    mag4_q <= mag3_q;
    neg4_q <= neg3_q;
    max4_q <= max_d;

    mag5_q   <= mag4_q;
    neg5_q   <= neg4_q;
    pos5_q   <= pos_d;
    degen5_q <= (max4_q == '0);

    // Shift all three so the leading one of the largest lands in the top bit
    for (int c = 0; c < 3; c++) begin
      if (pos5_q >= PosW'(NormTop)) begin
        side_q.mag[c] <= NormW'(mag5_q[c] >> (pos5_q - PosW'(NormTop)));
      end else begin
        side_q.mag[c] <= NormW'(64'(mag5_q[c]) << (PosW'(NormTop) - pos5_q));
      end
    end
    side_q.neg   <= neg5_q;
    side_q.degen <= degen5_q;
  end

  assign valid_o = vld_q[5];
  assign side_o  = side_q;

endmodule

### hw/rtl/tfn_isqrt.sv
module tfn_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  tfn_pkg::side_t             side_i,
  output logic                       valid_o,
  output tfn_pkg::side_t             side_o,
  output logic [tfn_pkg::LenW-1:0]   len_o
);
  import tfn_pkg::*;

  logic              sq_vld_q;
  logic [SqW-1:0]    sq_q [3];
  side_t             sq_side_q;

  logic              vld_q  [RootSteps+1];
  logic [RootW-1:0]  x_q    [RootSteps+1];
  logic [RootW-1:0]  r_q    [RootSteps+1];
  side_t             side_q [RootSteps+1];

  // Squares, then their sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
      vld_q[0] <= 1'b0;
    end else begin
      sq_vld_q <= valid_i;
      vld_q[0] <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      sq_q[c] <= side_i.mag[c] * side_i.mag[c];
    end
    sq_side_q <= side_i;
    x_q[0]    <= RootW'(sq_q[0]) + RootW'(sq_q[1]) + RootW'(sq_q[2]);
    r_q[0]    <= '0;
    side_q[0] <= sq_side_q;
  end

  // One root bit per stage
  for (genvar s = 0; s < RootSteps; s++) begin : g_step
    localparam logic [RootW-1:0] Bit = RootW'(1) << (Len2W - 2 * s);
    logic [RootW-1:0] trial;

    assign trial = r_q[s] + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (x_q[s] >= trial) begin
        x_q[s+1] <= x_q[s] - trial;
        r_q[s+1] <= (r_q[s] >> 1) + Bit;
      end else begin
        x_q[s+1] <= x_q[s];
        r_q[s+1] <= r_q[s] >> 1;
      end
      side_q[s+1] <= side_q[s];
    end
  end

  assign valid_o = vld_q[RootSteps];
  assign side_o  = side_q[RootSteps];
  assign len_o   = r_q[RootSteps][LenW-1:0];

endmodule

### hw/rtl/tfn_div.sv
module tfn_div #(
  parameter int FracBits = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  tfn_pkg::side_t           side_i,
  input  logic [tfn_pkg::LenW-1:0] len_i,
  output logic                     valid_o,
  output tfn_pkg::normal_t         normal_o
);
  import tfn_pkg::*;

  localparam int Q  = FracBits + 1;
  localparam int DW = LenW + FracBits;
  localparam logic [31:0] OneF = 32'd1 << FracBits;
  localparam logic [31:0] MaxMag = 32'(OutMax);

  logic            vld_q   [Q+1];
  logic [DW-1:0]   rem_q   [Q+1][3];
  logic [Q-1:0]    quo_q   [Q+1][3];
  logic [LenW-1:0] len_q   [Q+1];
  logic [2:0]      neg_q   [Q+1];
  logic            degen_q [Q+1];
  logic            out_vld_q;
  normal_t         out_q;

  logic [31:0]     clip_d [3];
  logic [OutW-1:0] comp_d [3];

  // Load numerators with the rounding half-divisor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0]  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q[0]  <= valid_i;
      out_vld_q <= vld_q[Q];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      rem_q[0][c] <= (DW'(side_i.mag[c]) << FracBits) + DW'(len_i >> 1);
      quo_q[0][c] <= '0;
    end
    len_q[0]   <= len_i;
    neg_q[0]   <= side_i.neg;
    degen_q[0] <= side_i.degen;
  end

  // One quotient bit per stage, three lanes
  for (genvar j = 1; j <= Q; j++) begin : g_step
    logic [DW-1:0] dvs;

    assign dvs = DW'(len_q[j-1]) << (Q - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      for (int c = 0; c < 3; c++) begin
        if (rem_q[j-1][c] >= dvs) begin
          rem_q[j][c] <= rem_q[j-1][c] - dvs;
          quo_q[j][c] <= {quo_q[j-1][c][Q-2:0], 1'b1};
        end else begin
          rem_q[j][c] <= rem_q[j-1][c];
          quo_q[j][c] <= {quo_q[j-1][c][Q-2:0], 1'b0};
        end
      end
      len_q[j]   <= len_q[j-1];
      neg_q[j]   <= neg_q[j-1];
      degen_q[j] <= degen_q[j-1];
    end
  end

  // Clamp to one and to the field range, then apply sign; degenerate items give zero
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      clip_d[c] = 32'(quo_q[Q][c]);
      if (clip_d[c] > OneF) clip_d[c] = OneF;
      if (clip_d[c] > MaxMag) clip_d[c] = MaxMag;
      comp_d[c] = neg_q[Q][c] ? OutW'(-clip_d[c]) : OutW'(clip_d[c]);
      if (degen_q[Q]) comp_d[c] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.normal_x   <= comp_d[0];
    out_q.normal_y   <= comp_d[1];
    out_q.normal_z   <= comp_d[2];
    out_q.degenerate <= degen_q[Q];
  end

  assign valid_o  = out_vld_q;
  assign normal_o = out_q;

endmodule

### hw/rtl/triangle_face_normal.sv
// Unit face normal of a triangle.
// Input channel: drive tri_i (vertices a, b, c, signed 16-bit coordinates)
// and raise start_i; the item is taken at the clock edge where start_i is
// high and busy_o is low. busy_o is always low, so a triangle may be issued
// in every cycle: throughput is one item per clock.
// Output channel: done_o is high for exactly one cycle with normal_o, the
// unit normal of (c-a) x (b-a) in signed Q1.NORMAL_FRAC_BITS, rounded half
// away from zero. A zero cross product gives a zero vector with degenerate set.
// Pipeline, in order: edges, cross product and normalizing shift; squares,
// sum and the one-bit-per-stage square root; the one-bit-per-stage divider
// lanes and the output clamp.
// Results leave in issue order and cannot be held off by the receiver.
// Reset clears all valid bits; items in flight at reset are dropped.
module triangle_face_normal #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  tfn_pkg::tri_t    tri_i,
  output logic             done_o,
  output tfn_pkg::normal_t normal_o
);
  import tfn_pkg::*;

  logic            cr_vld;
  side_t           cr_side;
  logic            sq_vld;
  side_t           sq_side;
  logic [LenW-1:0] sq_len;

  // Never stall the input
  assign busy_o = 1'b0;

  tfn_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .tri_i   (tri_i),
    .valid_o (cr_vld),
    .side_o  (cr_side)
  );

  tfn_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cr_vld),
    .side_i  (cr_side),
    .valid_o (sq_vld),
    .side_o  (sq_side),
    .len_o   (sq_len)
  );

  tfn_div #(
    .FracBits (NORMAL_FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sq_vld),
    .side_i   (sq_side),
    .len_i    (sq_len),
    .valid_o  (done_o),
    .normal_o (normal_o)
  );

endmodule

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tfn_pkg::*;

  localparam int FracBits   = 14;
  localparam int Latency    = 43 + FracBits;
  localparam int NumRandom  = 1900;
  localparam int CycleLimit = 200000;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start_i = 1'b0;
  logic    busy_o;
  tri_t    tri_i = '0;
  logic    done_o;
  normal_t normal_o;

  triangle_face_normal #(.NORMAL_FRAC_BITS(FracBits)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .tri_i   (tri_i),
    .done_o  (done_o),
    .normal_o(normal_o)
  );

  always #2 clk_i = ~clk_i;

  normal_t normal_q[$];
  int      errors;
  int      cycles;
  int      n_degen;
  int      n_seen;

  // Integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Compute the unit normal of (c-a) x (b-a)
  function automatic normal_t face_normal(tri_t t);
    normal_t         r;
    longint          e1[3];
    longint          e2[3];
    longint          cr[3];
    longint unsigned mg[3];
    longint unsigned mx;
    longint unsigned len2;
    longint unsigned len;
    longint unsigned q;
    logic [15:0]     v;
    e1[0] = longint'(t.b_x) - longint'(t.a_x);
    e1[1] = longint'(t.b_y) - longint'(t.a_y);
    e1[2] = longint'(t.b_z) - longint'(t.a_z);
    e2[0] = longint'(t.c_x) - longint'(t.a_x);
    e2[1] = longint'(t.c_y) - longint'(t.a_y);
    e2[2] = longint'(t.c_z) - longint'(t.a_z);
    cr[0] = e2[1] * e1[2] - e2[2] * e1[1];
    cr[1] = e2[2] * e1[0] - e2[0] * e1[2];
    cr[2] = e2[0] * e1[1] - e2[1] * e1[0];
    r = '0;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = (cr[i] < 0) ? longint'(-cr[i]) : longint'(cr[i]);
      if (mg[i] > mx) mx = mg[i];
    end
    if (mx == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    // Bring the largest magnitude into [2^29, 2^30)
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mg[i] = mg[i] << 1;
    end
    len2 = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
    len = root_floor(len2);
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << FracBits) + (len >> 1)) / len;
      if (q > (64'd1 << FracBits)) q = 64'd1 << FracBits;
      if (q > OutMax) q = OutMax;
      v = (cr[i] < 0) ? 16'(-q) : 16'(q);
      case (i)
        0: r.normal_x = v;
        1: r.normal_y = v;
        default: r.normal_z = v;
      endcase
    end
    return r;
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 31)) - 16'sd16;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly proper triangles; some with repeated or collinear vertices
  function automatic tri_t rand_tri();
    tri_t t;
    int   k;
    t = tri_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
    t.a_x = rand_coord(); t.a_y = rand_coord(); t.a_z = rand_coord();
    t.b_x = rand_coord(); t.b_y = rand_coord(); t.b_z = rand_coord();
    t.c_x = rand_coord(); t.c_y = rand_coord(); t.c_z = rand_coord();
    k = $urandom_range(0, 19);
    if (k == 0) begin
      t.c_x = t.a_x; t.c_y = t.a_y; t.c_z = t.a_z;
    end else if (k == 1) begin
      t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
    end else if (k == 2) begin
      t.c_x = t.b_x + (t.b_x - t.a_x);
      t.c_y = t.b_y + (t.b_y - t.a_y);
      t.c_z = t.b_z + (t.b_z - t.a_z);
    end
    return t;
  endfunction

  // Check each result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      normal_t exp_n;
      if (normal_q.size() == 0) begin
        $error("unexpected result %h", normal_o);
        errors++;
      end else begin
        exp_n = normal_q.pop_front();
        n_seen++;
        if (exp_n.degenerate) n_degen++;
        if (normal_o.normal_x !== exp_n.normal_x) begin
          $error("normal_x exp %0d got %0d", exp_n.normal_x, normal_o.normal_x);
          errors++;
        end
        if (normal_o.normal_y !== exp_n.normal_y) begin
          $error("normal_y exp %0d got %0d", exp_n.normal_y, normal_o.normal_y);
          errors++;
        end
        if (normal_o.normal_z !== exp_n.normal_z) begin
          $error("normal_z exp %0d got %0d", exp_n.normal_z, normal_o.normal_z);
          errors++;
        end
        if (normal_o.degenerate !== exp_n.degenerate) begin
          $error("degenerate exp %0b got %0b", exp_n.degenerate, normal_o.degenerate);
          errors++;
        end
      end
    end
  end

  // Abort on runaway
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one item and hold it until taken
  task automatic issue_tri(tri_t t, normal_t exp_n);
    tri_i   <= t;
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    normal_q = {normal_q, exp_n};
  endtask

  typedef struct {
    tri_t    t;
    logic    typed;
    normal_t n;
  } row_t;

  row_t rows[$];

  function automatic tri_t mk(int ax, int ay, int az, int bx, int by, int bz,
                              int cx, int cy, int cz);
    tri_t t;
    t.a_x = 16'(ax); t.a_y = 16'(ay); t.a_z = 16'(az);
    t.b_x = 16'(bx); t.b_y = 16'(by); t.b_z = 16'(bz);
    t.c_x = 16'(cx); t.c_y = 16'(cy); t.c_z = 16'(cz);
    return t;
  endfunction

  // Append one directed row
  function automatic void add_row(tri_t t, logic typed, normal_t n);
    row_t r;
    r.t     = t;
    r.typed = typed;
    r.n     = n;
    rows = {rows, r};
  endfunction

  initial begin
    int   gap;
    tri_t t;
    errors = 0;
    cycles = 0;
    n_degen = 0;
    n_seen = 0;
    // Directed rows: typed results for axis-aligned and degenerate cases, face_normal for the rest
    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{0, 0, 0, 1'b1});
    add_row(mk(5, 5, 5, 5, 5, 5, 5, 5, 5), 1'b1, '{0, 0, 0, 1'b1});
    add_row(mk(0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b1, '{0, 0, -16384, 1'b0});
    add_row(mk(0, 0, 0, 0, 1, 0, 1, 0, 0), 1'b1, '{0, 0, 16384, 1'b0});
    add_row(mk(0, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1, '{-16384, 0, 0, 1'b0});
    add_row(mk(0, 0, 0, 0, 0, 1, 1, 0, 0), 1'b1, '{0, -16384, 0, 1'b0});
    add_row(mk(0, 0, 0, 1, 1, 1, 2, 2, 2), 1'b1, '{0, 0, 0, 1'b1});
    add_row(mk(-32768, -32768, -32768, 32767, -32768, -32768,
               -32768, 32767, -32768), 1'b1, '{0, 0, -16384, 1'b0});
    add_row(mk(32767, 32767, 32767, 32767, 32767, 32767,
               -32768, -32768, -32768), 1'b1, '{0, 0, 0, 1'b1});
    add_row(mk(-32768, -32768, -32768, 32767, 32767, 32767,
               32767, -32768, 32767), 1'b0, '0);
    add_row(mk(32767, -32768, 0, -32768, 32767, 32767,
               0, 0, -32768), 1'b0, '0);
    add_row(mk(-1, -1, -1, 0, -1, -1, -1, 0, -1), 1'b0, '0);
    add_row(mk(0, 0, 0, 1, 2, 3, 4, 5, 7), 1'b0, '0);
    add_row(mk(0, 0, 0, 1, 0, 0, 1, 1, 0), 1'b0, '0);
    add_row(mk(-32768, 32767, -32768, 32767, -32768, 32767,
               -32767, 32766, -32768), 1'b0, '0);
    add_row(mk(100, 200, 300, -400, 500, -600, 700, -800, 900), 1'b0, '0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) issue_tri(rows[i].t, rows[i].typed ? rows[i].n : face_normal(rows[i].t));

    // Random stream with bursts of idle cycles, none in the last stretch
    for (int i = 0; i < NumRandom; i++) begin
      if (i < NumRandom - 300 && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 10);
        start_i <= 1'b0;
        tri_i   <= tri_t'({$urandom, $urandom, $urandom, $urandom, 16'($urandom)});
        repeat (gap) @(posedge clk_i);
      end
      t = rand_tri();
      issue_tri(t, face_normal(t));
    end
    start_i <= 1'b0;

    // Drain outstanding results, then allow for the pipeline depth
    while (normal_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);

    $display("Checked %0d triangle normals, %0d of them degenerate.", n_seen, n_degen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/tfn_pkg.sv
hw/rtl/tfn_cross.sv
hw/rtl/tfn_isqrt.sv
hw/rtl/tfn_div.sv
hw/rtl/triangle_face_normal.sv
tb/tb_top.sv
